[design/mpp_pkg.sv]
// Shared types and constants of the multichannel percent PWM timer.
// No dependencies; imported by the top level.
package mpp_pkg;

  localparam int TICK_W   = 16;  // period and on-time width
  localparam int DUTY_W   = 7;   // duty in percent
  localparam int CCOUNT_W = 17;  // per-channel counter width
  localparam int MASK_W   = 4;   // channels reported in the mask
  localparam int DUTY_REGS = 4;  // channels that own a duty register
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // on-time = (duty * period + 50) / 100
  localparam int PROD_W      = DUTY_W + TICK_W;
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam int QUOT_W      = PROD_W + RECIP_W;
  // ceil(2^30 / 100); exact floor for every numerator below 2^23
  localparam logic [RECIP_W-1:0] RECIP_100  = 24'd10737419;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 23'd50;
  localparam logic [DUTY_W-1:0]  DUTY_MAX   = 7'd100;

  localparam logic [TICK_W-1:0] PERIOD_RESET = 16'd100;

  // refresh latency of the on-time pipeline
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PERIOD = 3'd0;
  localparam cfg_index_t REG_DUTY0  = 3'd1;

endpackage

[design/multichannel_percent_pwm.sv]
// Multichannel percent PWM timer: one item advances (or samples) all channels at once.
// On-time pipeline, shared period counter, per-channel counters, registered result.
// Depends on mpp_pkg.
//
// One request per clock, back to back; each result appears on the cycle after its request is
// accepted. A result held by result_stall stays in the output register and stalls new requests
// until it is taken; when it is taken, the next request is accepted on the same edge. The on-time
// of every channel, (duty * period + 50) / 100, comes from a two-stage pipeline (product, then
// reciprocal multiply) fed by the configuration registers, so item_stall is held while a
// configuration write is offered, and after reset and after every configuration write while
// that pipeline refreshes. A period of zero halts the timer with all outputs off.
// Channels above the fourth have no duty register and stay off.
module multichannel_percent_pwm #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          advance,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [mpp_pkg::MASK_W-1:0]    channel_on_mask,
  output logic                          cycle_start,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  mpp_pkg::cfg_index_t           cfg_index,
  input  logic [mpp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mpp_pkg::*;

  logic [TICK_W-1:0]   period_ticks;
  logic [DUTY_W-1:0]   duty [NUM_CHANNELS];
  logic [PROD_W-1:0]   prod_scaled [NUM_CHANNELS];
  logic [TICK_W-1:0]   on_time [NUM_CHANNELS];
  logic [QUOT_W-1:0]   quot_full [NUM_CHANNELS];
  logic [1:0]          settle;

  logic [TICK_W-1:0]   period_count;
  logic [TICK_W-1:0]   period_count_next;
  logic [TICK_W:0]     period_count_inc;
  logic [CCOUNT_W-1:0] channel_count [NUM_CHANNELS];
  logic [CCOUNT_W-1:0] channel_count_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] on_vec;
  logic                wrap;
  logic                step;
  logic                item_take;
  logic                cfg_take;
  logic                out_free;

  assign cfg_ready  = 1'b1;
  assign cfg_take   = cfg_valid && cfg_ready;
  assign out_free   = !(result_valid && result_stall);
  assign item_stall = !out_free || (settle != 2'd0) || cfg_valid;
  assign item_take  = item_valid && !item_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= PERIOD_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++) duty[c] <= '0;
    end else if (cfg_take) begin
      if (cfg_index == REG_PERIOD) begin
        period_ticks <= cfg_data[TICK_W-1:0];
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (c < DUTY_REGS && cfg_index == cfg_index_t'(REG_DUTY0 + c) &&
            cfg_data[DUTY_W-1:0] <= DUTY_MAX) begin
          duty[c] <= cfg_data[DUTY_W-1:0];
        end
      end
    end
  end

  // hold off requests until the on-time pipeline reflects the registers
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= SETTLE_CYCLES;
    end else if (cfg_take) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // on-time pipeline: rounded product, then divide by 100 via reciprocal
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      quot_full[c] = QUOT_W'(prod_scaled[c]) * QUOT_W'(RECIP_100);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      prod_scaled[c] <= PROD_W'(PROD_W'(duty[c]) * PROD_W'(period_ticks)) + ROUND_HALF;
      on_time[c]     <= quot_full[c][RECIP_SHIFT +: TICK_W];
    end
  end

  // one tick of the timer
  assign step             = advance && (period_ticks != '0);
  assign period_count_inc = {1'b0, period_count} + (TICK_W+1)'(1);
  assign wrap             = step && (period_count_inc > {1'b0, period_ticks});

  always_comb begin
    period_count_next = period_count;
    if (step) begin
      period_count_next = wrap ? '0 : period_count_inc[TICK_W-1:0];
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      channel_count_next[c] = channel_count[c];
      if (wrap) begin
        channel_count_next[c] = '0;
      end else if (step && on_time[c] != '0 &&
                   channel_count[c] <= CCOUNT_W'(on_time[c])) begin
        channel_count_next[c] = channel_count[c] + CCOUNT_W'(1);
      end
      on_vec[c] = (period_ticks != '0) && (on_time[c] != '0) &&
                  (channel_count_next[c] <= CCOUNT_W'(on_time[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) channel_count[c] <= '0;
    end else if (cfg_take) begin
      // a new period value restarts the cycle; channel counters keep running
      if (cfg_index == REG_PERIOD && cfg_data[TICK_W-1:0] != period_ticks) begin
        period_count <= '0;
      end
    end else if (item_take) begin
      period_count <= period_count_next;
      for (int c = 0; c < NUM_CHANNELS; c++) channel_count[c] <= channel_count_next[c];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= item_take;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && item_take) begin
      channel_on_mask <= MASK_W'(on_vec);
      cycle_start     <= wrap;
    end
  end

`ifndef SYNTHESIS
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    item_take && period_ticks == '0 |=> channel_on_mask == '0 && !cycle_start)
    else $error("halted timer produced output");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    period_count <= period_ticks)
    else $error("period counter beyond period");

  a_settle_hold: assert property (@(posedge clk) disable iff (rst)
    settle != 2'd0 |-> !item_take)
    else $error("request taken while on-time pipeline refreshes");

  a_wrap_clears: assert property (@(posedge clk) disable iff (rst)
    item_take && wrap |=> period_count == '0 && cycle_start)
    else $error("wrap did not clear period counter");
`endif

endmodule
